// ===== hw/rtl/ipv4_fragment_reassembly_tracker_assert.svh =====
// ----------------------------------------------------------------------------
// ipv4 fragment reassembly tracker assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef IPV4_FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH
`define IPV4_FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH

// same-cycle implication
`define FRT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define FRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/ipv4_frt_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4_frt_pkg
// shared types and constants of the ipv4 fragment reassembly tracker
// ----------------------------------------------------------------------------
package ipv4_frt_pkg;

    localparam logic [2:0] STATUS_IGNORED   = 3'd0;
    localparam logic [2:0] STATUS_MALFORMED = 3'd1;
    localparam logic [2:0] STATUS_DROPPED   = 3'd2;
    localparam logic [2:0] STATUS_QUEUED    = 3'd3;
    localparam logic [2:0] STATUS_DONE      = 3'd4;

    localparam logic [1:0] CFG_ENTRY_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_BYTE_BUDGET  = 2'd1;
    localparam logic [1:0] CFG_IDLE_TIMEOUT = 2'd2;

    localparam logic [3:0]  RST_ENTRY_LIMIT  = 4'd8;
    localparam logic [18:0] RST_BYTE_BUDGET  = 19'd262144;
    localparam logic [31:0] RST_IDLE_TIMEOUT = 32'd30;

    localparam logic [17:0] MAX_TOTAL  = 18'd65535;
    localparam logic [5:0]  MIN_HEADER = 6'd20;
    localparam logic [3:0]  IP_V4      = 4'd4;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  proto;
        logic [15:0] ident;
    } key_t;

    typedef struct packed {
        logic        ignored;
        logic        malformed;
        key_t        key;
        logic [15:0] start;
        logic [16:0] stop;
        logic        more_frag;
        logic [5:0]  hdr;
        logic [31:0] now;
    } item_t;

    typedef struct packed {
        logic [3:0]  entry_limit;
        logic [18:0] byte_budget;
        logic [31:0] idle_timeout;
    } cfg_t;

    typedef struct packed {
        logic [15:0] lo;
        logic [16:0] hi;
    } range_t;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_LOOKUP,
        SEQ_ENTRY,
        SEQ_OVL_RD,
        SEQ_OVL_CHK,
        SEQ_SH_RD,
        SEQ_SH_CHK,
        SEQ_BUDGET,
        SEQ_CV_RD,
        SEQ_CV_CHK,
        SEQ_RESULT
    } seq_state_t;

endpackage

// ===== hw/rtl/ipv4_frt_front.sv =====
// ----------------------------------------------------------------------------
// ipv4_frt_front
// accepts fragment transactions and classifies them for the queue
// ----------------------------------------------------------------------------
module ipv4_frt_front #(
    parameter int MAX_HEADER = 60
) (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_is_fragment,
    input  logic [3:0]            s_ip_version,
    input  logic [31:0]           s_source_address,
    input  logic [31:0]           s_dest_address,
    input  logic [7:0]            s_protocol_number,
    input  logic [15:0]           s_ident,
    input  logic [15:0]           s_offset_bytes,
    input  logic [15:0]           s_payload_bytes,
    input  logic                  s_more_fragments,
    input  logic [5:0]            s_header_bytes,
    input  logic [31:0]           s_now_time,
    input  logic                  q_full,
    output logic                  q_push,
    output ipv4_frt_pkg::item_t   q_item
);
    import ipv4_frt_pkg::*;

    logic [17:0] sum_total;
    logic        bad;

    assign sum_total = 18'(s_offset_bytes) + 18'(s_payload_bytes) + 18'(s_header_bytes);

    always_comb begin
        bad = (s_ip_version != IP_V4) || (s_header_bytes < MIN_HEADER) ||
              (s_header_bytes > 6'(MAX_HEADER)) ||
              (s_more_fragments && (s_payload_bytes[2:0] != 3'd0)) ||
              (s_payload_bytes == 16'd0) || (sum_total > MAX_TOTAL);
    end

    always_comb begin
        q_item.ignored   = !s_is_fragment;
        q_item.malformed = bad;
        q_item.key.src   = s_source_address;
        q_item.key.dst   = s_dest_address;
        q_item.key.proto = s_protocol_number;
        q_item.key.ident = s_ident;
        q_item.start     = s_offset_bytes;
        q_item.stop      = 17'(s_offset_bytes) + 17'(s_payload_bytes);
        q_item.more_frag = s_more_fragments;
        q_item.hdr       = s_header_bytes;
        q_item.now       = s_now_time;
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

endmodule

// ===== hw/rtl/ipv4_frt_queue.sv =====
// ----------------------------------------------------------------------------
// ipv4_frt_queue
// two-entry queue between the front and the back end
// ----------------------------------------------------------------------------
module ipv4_frt_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  ipv4_frt_pkg::item_t   push_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  pop_valid,
    output ipv4_frt_pkg::item_t   pop_item
);
    import ipv4_frt_pkg::*;

    item_t       slot_reg [2];
    logic [1:0]  count_reg, count_next;
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hw/rtl/ipv4_frt_back.sv =====
// ----------------------------------------------------------------------------
// ipv4_frt_back
// sequencer that expires, looks up and updates the partial datagram table
// ----------------------------------------------------------------------------
module ipv4_frt_back #(
    parameter int TABLE_ENTRIES    = 8,
    parameter int RANGES_PER_ENTRY = 16,
    parameter int BYTE_POOL        = 262144
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ipv4_frt_pkg::cfg_t    cfg,
    input  logic                  q_valid,
    input  ipv4_frt_pkg::item_t   q_item,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_status,
    output logic [15:0]           m_total_length,
    output logic [3:0]            m_expired_count
);
    import ipv4_frt_pkg::*;

    localparam int EIW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int RIW = (RANGES_PER_ENTRY > 1) ? $clog2(RANGES_PER_ENTRY) : 1;
    localparam int CW  = $clog2(TABLE_ENTRIES + 1);
    localparam int RCW = $clog2(RANGES_PER_ENTRY + 1);
    localparam int MEM_DEPTH = 1 << (EIW + RIW);

    // table
    logic              valid_reg    [TABLE_ENTRIES];
    key_t              key_reg      [TABLE_ENTRIES];
    logic [31:0]       seen_reg     [TABLE_ENTRIES];
    logic [5:0]        hdr_reg      [TABLE_ENTRIES];
    logic [16:0]       res_reg      [TABLE_ENTRIES];
    logic              flag_reg     [TABLE_ENTRIES];
    logic [16:0]       ptotal_reg   [TABLE_ENTRIES];
    logic [RCW-1:0]    rc_reg       [TABLE_ENTRIES];
    range_t            range_mem    [MEM_DEPTH];
    range_t            rd_data_reg;

    seq_state_t        state_reg, state_next;
    item_t             item_reg, item_next;
    logic [EIW-1:0]    idx_reg, idx_next;
    logic [EIW-1:0]    match_reg, match_next;
    logic [EIW-1:0]    free_reg, free_next;
    logic              found_reg, found_next;
    logic              free_ok_reg, free_ok_next;
    logic              alloc_reg, alloc_next;
    logic [3:0]        exp_reg, exp_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [18:0]       in_use_reg, in_use_next;
    logic [RCW-1:0]    ri_reg, ri_next;
    logic [16:0]       cov_reg, cov_next;
    logic [2:0]        status_reg, status_next;
    logic [15:0]       total_reg, total_next;
    logic              m_valid_reg, m_valid_next;
    logic [2:0]        m_status_reg, m_status_next;
    logic [15:0]       m_total_reg, m_total_next;
    logic [3:0]        m_exp_reg, m_exp_next;

    logic                  mem_we;
    logic [EIW+RIW-1:0]    mem_waddr, mem_raddr;
    range_t                mem_wdata, new_range;
    logic                  inval, alloc, touch, rc_inc, res_we, fin_we;

    logic [31:0]   idle;
    logic          exp_hit, key_hit;
    logic [18:0]   in_use_sub, budget;
    logic [16:0]   need;
    logic          budget_fail;
    logic [7:0]    lim;
    logic [RCW-1:0] ri_m1;
    logic          fin_flag;
    logic [16:0]   fin_total;
    logic [17:0]   dgram_len;

    assign new_range.lo = item_reg.start;
    assign new_range.hi = item_reg.stop;
    assign ri_m1        = ri_reg - RCW'(1);

    always_comb begin
        idle    = (item_reg.now >= seen_reg[idx_reg]) ? (item_reg.now - seen_reg[idx_reg]) : 32'd0;
        exp_hit = valid_reg[idx_reg] && (cfg.idle_timeout != 32'd0) &&
                  (idle >= cfg.idle_timeout);
        key_hit = valid_reg[idx_reg] && (key_reg[idx_reg] == item_reg.key);
        in_use_sub = (in_use_reg >= 19'(res_reg[idx_reg])) ?
                     (in_use_reg - 19'(res_reg[idx_reg])) : 19'd0;
        budget  = ({6'd0, cfg.byte_budget} < 25'(BYTE_POOL)) ? cfg.byte_budget
                                                              : 19'(BYTE_POOL);
        need    = item_reg.stop - res_reg[idx_reg];
        budget_fail = (item_reg.stop > res_reg[idx_reg]) &&
                      ((19'(need) > budget) || (in_use_reg > budget - 19'(need)));
        lim     = (8'(cfg.entry_limit) < 8'(TABLE_ENTRIES)) ? 8'(cfg.entry_limit)
                                                              : 8'(TABLE_ENTRIES);
        fin_flag  = !item_reg.more_frag || flag_reg[idx_reg];
        fin_total = item_reg.more_frag ? ptotal_reg[idx_reg] : item_reg.stop;
        dgram_len = 18'(hdr_reg[idx_reg]) + 18'(ptotal_reg[idx_reg]);
    end

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        idx_next      = idx_reg;
        match_next    = match_reg;
        free_next     = free_reg;
        found_next    = found_reg;
        free_ok_next  = free_ok_reg;
        alloc_next    = alloc_reg;
        exp_next      = exp_reg;
        count_next    = count_reg;
        in_use_next   = in_use_reg;
        ri_next       = ri_reg;
        cov_next      = cov_reg;
        status_next   = status_reg;
        total_next    = total_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_total_next  = m_total_reg;
        m_exp_next    = m_exp_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = {idx_reg, ri_reg[RIW-1:0]};
        mem_raddr     = {idx_reg, ri_reg[RIW-1:0]};
        mem_wdata     = new_range;
        inval         = 1'b0;
        alloc         = 1'b0;
        touch         = 1'b0;
        rc_inc        = 1'b0;
        res_we        = 1'b0;
        fin_we        = 1'b0;
        unique case (state_reg)
            SEQ_IDLE: begin
                if (q_valid) begin
                    q_pop        = 1'b1;
                    item_next    = q_item;
                    idx_next     = '0;
                    exp_next     = 4'd0;
                    found_next   = 1'b0;
                    free_ok_next = 1'b0;
                    total_next   = 16'd0;
                    if (q_item.ignored) begin
                        status_next = STATUS_IGNORED;
                        state_next  = SEQ_RESULT;
                    end else begin
                        state_next  = SEQ_SCAN;
                    end
                end
            end
            SEQ_SCAN: begin
                if (exp_hit) begin
                    inval       = 1'b1;
                    in_use_next = in_use_sub;
                    count_next  = count_reg - CW'(1);
                    exp_next    = exp_reg + 4'd1;
                end else if (key_hit) begin
                    found_next  = 1'b1;
                    match_next  = idx_reg;
                end
                if ((!valid_reg[idx_reg] || exp_hit) && !free_ok_reg) begin
                    free_ok_next = 1'b1;
                    free_next    = idx_reg;
                end
                if (idx_reg == EIW'(TABLE_ENTRIES - 1)) begin
                    state_next = SEQ_LOOKUP;
                end else begin
                    idx_next   = idx_reg + EIW'(1);
                end
            end
            SEQ_LOOKUP: begin
                if (item_reg.malformed) begin
                    status_next = STATUS_MALFORMED;
                    state_next  = SEQ_RESULT;
                end else if (found_reg) begin
                    idx_next    = match_reg;
                    alloc_next  = 1'b0;
                    state_next  = SEQ_ENTRY;
                end else if (8'(count_reg) >= lim) begin
                    status_next = STATUS_DROPPED;
                    state_next  = SEQ_RESULT;
                end else begin
                    idx_next    = free_reg;
                    alloc_next  = 1'b1;
                    count_next  = count_reg + CW'(1);
                    state_next  = SEQ_ENTRY;
                end
            end
            SEQ_ENTRY: begin
                touch   = 1'b1;
                ri_next = '0;
                if (alloc_reg) begin
                    alloc      = 1'b1;
                    state_next = SEQ_SH_RD;
                end else if (rc_reg[idx_reg] == RCW'(RANGES_PER_ENTRY)) begin
                    inval       = 1'b1;
                    in_use_next = in_use_sub;
                    count_next  = count_reg - CW'(1);
                    status_next = STATUS_MALFORMED;
                    state_next  = SEQ_RESULT;
                end else if (rc_reg[idx_reg] == '0) begin
                    state_next = SEQ_SH_RD;
                end else begin
                    state_next = SEQ_OVL_RD;
                end
            end
            SEQ_OVL_RD: begin
                state_next = SEQ_OVL_CHK;
            end
            SEQ_OVL_CHK: begin
                if ((17'(item_reg.start) < rd_data_reg.hi) &&
                    (item_reg.stop > 17'(rd_data_reg.lo))) begin
                    inval       = 1'b1;
                    in_use_next = in_use_sub;
                    count_next  = count_reg - CW'(1);
                    status_next = STATUS_MALFORMED;
                    state_next  = SEQ_RESULT;
                end else if (ri_reg + RCW'(1) == rc_reg[idx_reg]) begin
                    ri_next    = rc_reg[idx_reg];
                    state_next = SEQ_SH_RD;
                end else begin
                    ri_next    = ri_reg + RCW'(1);
                    state_next = SEQ_OVL_RD;
                end
            end
            SEQ_SH_RD: begin
                if (ri_reg == '0) begin
                    mem_we     = 1'b1;
                    state_next = SEQ_BUDGET;
                end else begin
                    mem_raddr  = {idx_reg, ri_m1[RIW-1:0]};
                    state_next = SEQ_SH_CHK;
                end
            end
            SEQ_SH_CHK: begin
                mem_we = 1'b1;
                if (rd_data_reg.lo > item_reg.start) begin
                    mem_wdata  = rd_data_reg;
                    ri_next    = ri_m1;
                    state_next = SEQ_SH_RD;
                end else begin
                    state_next = SEQ_BUDGET;
                end
            end
            SEQ_BUDGET: begin
                if (budget_fail) begin
                    inval       = 1'b1;
                    in_use_next = in_use_sub;
                    count_next  = count_reg - CW'(1);
                    status_next = STATUS_DROPPED;
                    state_next  = SEQ_RESULT;
                end else begin
                    rc_inc = 1'b1;
                    fin_we = !item_reg.more_frag;
                    if (item_reg.stop > res_reg[idx_reg]) begin
                        res_we      = 1'b1;
                        in_use_next = in_use_reg + 19'(need);
                    end
                    ri_next  = '0;
                    cov_next = 17'd0;
                    if (!fin_flag || (fin_total == 17'd0)) begin
                        status_next = STATUS_QUEUED;
                        state_next  = SEQ_RESULT;
                    end else begin
                        state_next  = SEQ_CV_RD;
                    end
                end
            end
            SEQ_CV_RD: begin
                if (ri_reg == rc_reg[idx_reg]) begin
                    status_next = STATUS_QUEUED;
                    state_next  = SEQ_RESULT;
                end else begin
                    state_next  = SEQ_CV_CHK;
                end
            end
            SEQ_CV_CHK: begin
                if (17'(rd_data_reg.lo) != cov_reg) begin
                    status_next = STATUS_QUEUED;
                    state_next  = SEQ_RESULT;
                end else if (rd_data_reg.hi == ptotal_reg[idx_reg]) begin
                    inval       = 1'b1;
                    in_use_next = in_use_sub;
                    count_next  = count_reg - CW'(1);
                    state_next  = SEQ_RESULT;
                    if (dgram_len > MAX_TOTAL) begin
                        status_next = STATUS_DROPPED;
                    end else begin
                        status_next = STATUS_DONE;
                        total_next  = dgram_len[15:0];
                    end
                end else if (rd_data_reg.hi > ptotal_reg[idx_reg]) begin
                    status_next = STATUS_QUEUED;
                    state_next  = SEQ_RESULT;
                end else begin
                    cov_next   = rd_data_reg.hi;
                    ri_next    = ri_reg + RCW'(1);
                    state_next = SEQ_CV_RD;
                end
            end
            SEQ_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_total_next  = total_reg;
                    m_exp_next    = exp_reg;
                    state_next    = SEQ_IDLE;
                end
            end
            default: begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SEQ_IDLE;
            count_reg   <= '0;
            in_use_reg  <= 19'd0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            in_use_reg  <= in_use_next;
            m_valid_reg <= m_valid_next;
            if (inval) begin
                valid_reg[idx_reg] <= 1'b0;
            end else if (alloc) begin
                valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        idx_reg      <= idx_next;
        match_reg    <= match_next;
        free_reg     <= free_next;
        found_reg    <= found_next;
        free_ok_reg  <= free_ok_next;
        alloc_reg    <= alloc_next;
        exp_reg      <= exp_next;
        ri_reg       <= ri_next;
        cov_reg      <= cov_next;
        status_reg   <= status_next;
        total_reg    <= total_next;
        m_status_reg <= m_status_next;
        m_total_reg  <= m_total_next;
        m_exp_reg    <= m_exp_next;
        if (alloc) begin
            key_reg[idx_reg] <= item_reg.key;
            hdr_reg[idx_reg] <= item_reg.hdr;
        end
        if (touch) begin
            seen_reg[idx_reg] <= item_reg.now;
        end
        if (alloc) begin
            rc_reg[idx_reg] <= '0;
        end else if (rc_inc) begin
            rc_reg[idx_reg] <= rc_reg[idx_reg] + RCW'(1);
        end
        if (alloc) begin
            res_reg[idx_reg] <= 17'd0;
        end else if (res_we) begin
            res_reg[idx_reg] <= item_reg.stop;
        end
        if (alloc) begin
            flag_reg[idx_reg]   <= 1'b0;
            ptotal_reg[idx_reg] <= 17'd0;
        end else if (fin_we) begin
            flag_reg[idx_reg]   <= 1'b1;
            ptotal_reg[idx_reg] <= item_reg.stop;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            range_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= range_mem[mem_raddr];
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_total_length  = m_total_reg;
    assign m_expired_count = m_exp_reg;

endmodule

// ===== hw/rtl/ipv4_fragment_reassembly_tracker.sv =====
// ----------------------------------------------------------------------------
// ipv4_fragment_reassembly_tracker
// tracks partial ipv4 datagrams and reports queued, dropped or complete
// ----------------------------------------------------------------------------
// sequence: an ignored transaction goes straight to the result; a fragment first scans
//   every table entry for expiry and a key match and is then looked up; a stored one
//   checks overlap with and shifts its ranges, then checks coverage once the total is known
// the back end takes the next transaction the cycle after a result loads, so it handles
//   one at a time; a two-entry queue takes new transactions meanwhile
// reset: synchronous; clears table valid bits, counters, output valid; loads config defaults
module ipv4_fragment_reassembly_tracker #(
    parameter int TABLE_ENTRIES    = 8,
    parameter int RANGES_PER_ENTRY = 16,
    parameter int BYTE_POOL        = 262144,
    parameter int MAX_HEADER       = 60
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_is_fragment,
    input  logic [3:0]  s_ip_version,
    input  logic [31:0] s_source_address,
    input  logic [31:0] s_dest_address,
    input  logic [7:0]  s_protocol_number,
    input  logic [15:0] s_ident,
    input  logic [15:0] s_offset_bytes,
    input  logic [15:0] s_payload_bytes,
    input  logic        s_more_fragments,
    input  logic [5:0]  s_header_bytes,
    input  logic [31:0] s_now_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_total_length,
    output logic [3:0]  m_expired_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import ipv4_frt_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    item_t front_item, q_item;
    logic  q_full, q_push, q_pop, q_valid;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ENTRY_LIMIT:  cfg_next.entry_limit  = cfg_data[3:0];
                CFG_BYTE_BUDGET:  cfg_next.byte_budget  = cfg_data[18:0];
                CFG_IDLE_TIMEOUT: cfg_next.idle_timeout = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.entry_limit  <= RST_ENTRY_LIMIT;
            cfg_reg.byte_budget  <= RST_BYTE_BUDGET;
            cfg_reg.idle_timeout <= RST_IDLE_TIMEOUT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ipv4_frt_front #(
        .MAX_HEADER(MAX_HEADER)
    ) u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_is_fragment    (s_is_fragment),
        .s_ip_version     (s_ip_version),
        .s_source_address (s_source_address),
        .s_dest_address   (s_dest_address),
        .s_protocol_number(s_protocol_number),
        .s_ident          (s_ident),
        .s_offset_bytes   (s_offset_bytes),
        .s_payload_bytes  (s_payload_bytes),
        .s_more_fragments (s_more_fragments),
        .s_header_bytes   (s_header_bytes),
        .s_now_time       (s_now_time),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_item           (front_item)
    );

    ipv4_frt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_item(front_item),
        .full     (q_full),
        .pop      (q_pop),
        .pop_valid(q_valid),
        .pop_item (q_item)
    );

    ipv4_frt_back #(
        .TABLE_ENTRIES   (TABLE_ENTRIES),
        .RANGES_PER_ENTRY(RANGES_PER_ENTRY),
        .BYTE_POOL       (BYTE_POOL)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_total_length (m_total_length),
        .m_expired_count(m_expired_count)
    );

endmodule

// ===== hw/rtl/ipv4_frt_checker.sv =====
// ----------------------------------------------------------------------------
// ipv4_frt_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "ipv4_fragment_reassembly_tracker_assert.svh"

module ipv4_frt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [15:0] m_total_length,
    input logic [3:0]  m_expired_count
);
    import ipv4_frt_pkg::*;

    `FRT_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_total_length))
    `FRT_ASSERT_IMPL(a_total_only_done, aclk, aresetn, m_valid && (m_status != STATUS_DONE), m_total_length == 16'd0)
    `FRT_ASSERT_IMPL(a_ignored_no_expiry, aclk, aresetn, m_valid && (m_status == STATUS_IGNORED), m_expired_count == 4'd0)
    `FRT_ASSERT_IMPL(a_done_min_length, aclk, aresetn, m_valid && (m_status == STATUS_DONE), m_total_length > 16'd20)

endmodule

bind ipv4_fragment_reassembly_tracker ipv4_frt_checker u_checker (.*);
